[hw/rtl/mrtu_pkg.sv]
package mrtu_pkg;

    // Operation codes of a request
    localparam logic [2:0] OP_STORE = 3'd0;
    localparam logic [2:0] OP_FETCH = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_RXB   = 3'd4;
    localparam logic [2:0] OP_EOF   = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_WRITE_ACK = 3'd0;
    localparam logic [2:0] ST_READ_OK   = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
    localparam logic [2:0] ST_NOT_PEND  = 3'd3;
    localparam logic [2:0] ST_BAD_CRC   = 3'd4;
    localparam logic [2:0] ST_BAD_LEN   = 3'd5;

    // Pending function
    localparam logic [1:0] FN_IDLE  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    // Modbus function bytes
    localparam logic [7:0] CODE_WRITE = 8'h10;
    localparam logic [7:0] CODE_READ  = 8'h03;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLAVE = 2'd0;
    localparam logic [1:0] CFG_WBASE = 2'd1;
    localparam logic [1:0] CFG_RBASE = 2'd2;

    // Reset values of configuration
    localparam logic [7:0]  SLAVE_RST = 8'd2;
    localparam logic [15:0] WBASE_RST = 16'd2000;
    localparam logic [15:0] RBASE_RST = 16'd1000;

    // CRC-16/Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [2:0]  operation;
        logic [5:0]  reg_index;
        logic [4:0]  reg_count;
        logic [15:0] reg_value;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [2:0]  status;
        logic [15:0] reg_value_out;
    } out_item_t;

    // Control of the shared CRC unit
    typedef struct packed {
        logic       init;
        logic       en;
        logic [7:0] data;
    } crc_ctrl_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH_RD,
        S_FETCH_OUT,
        S_TX_HDR,
        S_TX_RD,
        S_TX_HI,
        S_TX_LO,
        S_TX_CLO,
        S_TX_CHI,
        S_CHK_ADDR,
        S_CHK_FN,
        S_CHK_LEN,
        S_CRC_ISSUE,
        S_CRC_RUN,
        S_CMP_LO,
        S_CMP_HI,
        S_ST_HI_RD,
        S_ST_LO_RD,
        S_ST_WR,
        S_STAT
    } state_t;

    // One byte through the reflected CRC, eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[hw/rtl/mrtu_crc.sv]
module mrtu_crc (
    input  logic              clk,
    input  logic              rst_n,
    input  mrtu_pkg::crc_ctrl_t ctrl,
    output logic [15:0]       crc
);
    import mrtu_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // Byte-wide CRC accumulator shared by transmit and check
    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.init)
            crc_next = CRC_INIT;
        else if (ctrl.en)
            crc_next = crc_byte(crc_reg, ctrl.data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

[hw/rtl/modbus_rtu_master_framer.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------
// in       | to block  | in_valid / in_stall  | in_data  (in_item_t)
// out      | from block| out_valid / out_stall| out_data (out_item_t)
// cfg      | to block  | cfg_we               | cfg_index, cfg_data
//
// Store and rx byte requests are handled in the idle state. A fetch reads the store,
// then returns the value. A frame is sent as header, stored registers for a write, then
// CRC; an end-of-frame check runs the CRC over the checked bytes, then copies read registers to the store.
// The timing is set by the byte-wide CRC unit and the single store read port.
// After reset the holding store is cleared entry by entry with in_stall high.
// A stalled output only holds the sequencer at its next result.
module modbus_rtu_master_framer #(
    parameter int STORE_DEPTH = 64,
    parameter int MAX_REGS    = 16,
    parameter int RX_DEPTH    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mrtu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mrtu_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import mrtu_pkg::*;

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CWS   = $clog2(STORE_DEPTH + 1);
    localparam int CW    = (CWS > 9) ? CWS : 9;
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RCW   = $clog2(RX_DEPTH + 1);

    // Memories
    logic [15:0] store_mem [STORE_DEPTH];
    logic [7:0]  rx_mem    [RX_DEPTH];

    state_t      state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]  pos_reg, pos_next;
    logic [6:0]  word_reg, word_next;
    logic [8:0]  ptr_reg, ptr_next;
    logic [8:0]  len_reg, len_next;
    logic [7:0]  bytes_reg, bytes_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  status_reg, status_next;
    logic        eof_reg, eof_next;
    logic [RCW-1:0] rxcnt_reg, rxcnt_next;
    logic [1:0]  pfn_reg, pfn_next;
    logic [5:0]  pstart_reg, pstart_next;
    logic [5:0]  idx_reg, idx_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        wr_reg, wr_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  slave_reg;
    logic [15:0] wbase_reg;
    logic [15:0] rbase_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [15:0]   st_wdata, st_rdata_reg;
    logic          rx_we, rx_re;
    logic [RX_AW-1:0] rx_raddr;
    logic [7:0]    rx_rdata_reg;

    crc_ctrl_t     crc_ctrl;
    logic [15:0]   crc;

    logic          accept, slot_free, emit;
    out_item_t     emit_item;
    logic [CW-1:0] req_end;
    logic [9:0]    cnt10;
    logic [7:0]    hdr_byte;
    logic [7:0]    code_exp;

    mrtu_crc u_crc (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (crc_ctrl),
        .crc  (crc)
    );

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign req_end   = CW'(in_data.reg_index) + CW'(in_data.reg_count);
    assign cnt10     = 10'(rxcnt_reg);

    // Header byte of the request frame
    always_comb
    begin
        case (pos_reg)
            3'd0:    hdr_byte = slave_reg;
            3'd1:    hdr_byte = wr_reg ? CODE_WRITE : CODE_READ;
            3'd2:    hdr_byte = addr_reg[15:8];
            3'd3:    hdr_byte = addr_reg[7:0];
            3'd4:    hdr_byte = 8'h00;
            3'd5:    hdr_byte = 8'(cnt_reg);
            default: hdr_byte = 8'({cnt_reg, 1'b0});
        endcase
    end

    always_comb
    begin
        case (pfn_reg)
            FN_WRITE: code_exp = CODE_WRITE;
            FN_READ:  code_exp = CODE_READ;
            default:  code_exp = 8'h00;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        ptr_next    = ptr_reg;
        len_next    = len_reg;
        bytes_next  = bytes_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        eof_next    = eof_reg;
        rxcnt_next  = rxcnt_reg;
        pfn_next    = pfn_reg;
        pstart_next = pstart_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        wr_next     = wr_reg;
        addr_next   = addr_reg;
        st_we       = 1'b0;
        st_waddr    = clr_reg;
        st_wdata    = 16'h0000;
        st_re       = 1'b0;
        st_raddr    = AW'(idx_reg) + AW'(word_reg);
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        rx_raddr    = ptr_reg[RX_AW-1:0];
        crc_ctrl    = '0;
        emit        = 1'b0;
        emit_item   = '0;

        case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(STORE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = in_data.reg_index;
                    cnt_next  = in_data.reg_count;
                    pos_next  = 3'd0;
                    word_next = 7'd0;
                    eof_next  = 1'b0;
                    case (in_data.operation)
                        OP_STORE:
                        begin
                            if (CW'(in_data.reg_index) < CW'(STORE_DEPTH))
                            begin
                                st_we    = 1'b1;
                                st_waddr = AW'(in_data.reg_index);
                                st_wdata = in_data.reg_value;
                            end
                        end
                        OP_FETCH:
                            state_next = S_FETCH_RD;
                        OP_WRITE, OP_READ:
                        begin
                            if (in_data.reg_count == 5'd0 ||
                                32'(in_data.reg_count) > MAX_REGS ||
                                req_end > CW'(STORE_DEPTH))
                            begin
                                status_next = ST_BAD_LEN;
                                state_next  = S_STAT;
                            end
                            else
                            begin
                                wr_next       = (in_data.operation == OP_WRITE);
                                addr_next     = 16'(in_data.reg_index) +
                                    ((in_data.operation == OP_WRITE) ? wbase_reg : rbase_reg);
                                pfn_next      = (in_data.operation == OP_WRITE) ?
                                                FN_WRITE : FN_READ;
                                pstart_next   = in_data.reg_index;
                                crc_ctrl.init = 1'b1;
                                state_next    = S_TX_HDR;
                            end
                        end
                        OP_RXB:
                        begin
                            if (rxcnt_reg < RCW'(RX_DEPTH))
                            begin
                                rx_we      = 1'b1;
                                rxcnt_next = rxcnt_reg + 1'b1;
                            end
                        end
                        OP_EOF:
                        begin
                            eof_next   = 1'b1;
                            rx_re      = 1'b1;
                            rx_raddr   = '0;
                            state_next = S_CHK_ADDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH_RD:
            begin
                st_re      = 1'b1;
                st_raddr   = AW'(idx_reg);
                state_next = S_FETCH_OUT;
            end
            S_FETCH_OUT:
            begin
                if (slot_free)
                begin
                    emit                    = 1'b1;
                    emit_item.kind          = KIND_VALUE;
                    emit_item.reg_value_out =
                        (CW'(idx_reg) < CW'(STORE_DEPTH)) ? st_rdata_reg : 16'h0000;
                    state_next              = S_IDLE;
                end
            end
            // Request frame emission
            S_TX_HDR:
            begin
                if (slot_free)
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = hdr_byte;
                    crc_ctrl.en       = 1'b1;
                    crc_ctrl.data     = hdr_byte;
                    pos_next          = pos_reg + 1'b1;
                    if (pos_reg == 3'd5 && !wr_reg)
                        state_next = S_TX_CLO;
                    else if (pos_reg == 3'd6)
                        state_next = S_TX_RD;
                end
            end
            S_TX_RD:
            begin
                st_re      = 1'b1;
                state_next = S_TX_HI;
            end
            S_TX_HI:
            begin
                if (slot_free)
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = st_rdata_reg[15:8];
                    crc_ctrl.en       = 1'b1;
                    crc_ctrl.data     = st_rdata_reg[15:8];
                    state_next        = S_TX_LO;
                end
            end
            S_TX_LO:
            begin
                if (slot_free)
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = st_rdata_reg[7:0];
                    crc_ctrl.en       = 1'b1;
                    crc_ctrl.data     = st_rdata_reg[7:0];
                    if (word_reg == 7'(cnt_reg) - 7'd1)
                        state_next = S_TX_CLO;
                    else
                    begin
                        word_next  = word_reg + 7'd1;
                        state_next = S_TX_RD;
                    end
                end
            end
            S_TX_CLO:
            begin
                if (slot_free)
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = crc[7:0];
                    state_next        = S_TX_CHI;
                end
            end
            S_TX_CHI:
            begin
                if (slot_free)
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = crc[15:8];
                    emit_item.last    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            // Reply checks
            S_CHK_ADDR:
            begin
                if (rxcnt_reg == '0 || rx_rdata_reg != slave_reg)
                begin
                    status_next = ST_BAD_ADDR;
                    state_next  = S_STAT;
                end
                else
                begin
                    rx_re      = 1'b1;
                    rx_raddr   = RX_AW'(1);
                    state_next = S_CHK_FN;
                end
            end
            S_CHK_FN:
            begin
                if (cnt10 < 10'd2 || pfn_reg == FN_IDLE || rx_rdata_reg != code_exp)
                begin
                    status_next = ST_NOT_PEND;
                    state_next  = S_STAT;
                end
                else if (pfn_reg == FN_WRITE)
                begin
                    if (cnt10 < 10'd8)
                    begin
                        status_next = ST_BAD_LEN;
                        state_next  = S_STAT;
                    end
                    else
                    begin
                        len_next   = 9'd6;
                        state_next = S_CRC_ISSUE;
                    end
                end
                else if (cnt10 < 10'd3)
                begin
                    status_next = ST_BAD_LEN;
                    state_next  = S_STAT;
                end
                else
                begin
                    rx_re      = 1'b1;
                    rx_raddr   = RX_AW'(2);
                    state_next = S_CHK_LEN;
                end
            end
            S_CHK_LEN:
            begin
                bytes_next = rx_rdata_reg;
                if (10'(rx_rdata_reg) + 10'd5 > cnt10 ||
                    CW'(pstart_reg) + CW'(rx_rdata_reg[7:1]) > CW'(STORE_DEPTH))
                begin
                    status_next = ST_BAD_LEN;
                    state_next  = S_STAT;
                end
                else
                begin
                    len_next   = 9'(rx_rdata_reg) + 9'd3;
                    state_next = S_CRC_ISSUE;
                end
            end
            S_CRC_ISSUE:
            begin
                crc_ctrl.init = 1'b1;
                rx_re         = 1'b1;
                rx_raddr      = '0;
                ptr_next      = 9'd1;
                state_next    = S_CRC_RUN;
            end
            S_CRC_RUN:
            begin
                crc_ctrl.en   = 1'b1;
                crc_ctrl.data = rx_rdata_reg;
                rx_re         = 1'b1;
                ptr_next      = ptr_reg + 9'd1;
                if (ptr_reg == len_reg)
                    state_next = S_CMP_LO;
            end
            S_CMP_LO:
            begin
                byte_next  = rx_rdata_reg;
                rx_re      = 1'b1;
                state_next = S_CMP_HI;
            end
            S_CMP_HI:
            begin
                word_next = 7'd0;
                ptr_next  = 9'd3;
                if ({rx_rdata_reg, byte_reg} != crc)
                begin
                    status_next = ST_BAD_CRC;
                    state_next  = S_STAT;
                end
                else if (pfn_reg == FN_WRITE)
                begin
                    pfn_next    = FN_IDLE;
                    pstart_next = 6'd0;
                    status_next = ST_WRITE_ACK;
                    state_next  = S_STAT;
                end
                else if (bytes_reg[7:1] == 7'd0)
                begin
                    pfn_next    = FN_IDLE;
                    pstart_next = 6'd0;
                    status_next = ST_READ_OK;
                    state_next  = S_STAT;
                end
                else
                    state_next = S_ST_HI_RD;
            end
            // Copy read data into the holding store
            S_ST_HI_RD:
            begin
                rx_re      = 1'b1;
                ptr_next   = ptr_reg + 9'd1;
                state_next = S_ST_LO_RD;
            end
            S_ST_LO_RD:
            begin
                byte_next  = rx_rdata_reg;
                rx_re      = 1'b1;
                ptr_next   = ptr_reg + 9'd1;
                state_next = S_ST_WR;
            end
            S_ST_WR:
            begin
                st_we    = 1'b1;
                st_waddr = AW'(pstart_reg) + AW'(word_reg);
                st_wdata = {byte_reg, rx_rdata_reg};
                if (word_reg == bytes_reg[7:1] - 7'd1)
                begin
                    pfn_next    = FN_IDLE;
                    pstart_next = 6'd0;
                    status_next = ST_READ_OK;
                    state_next  = S_STAT;
                end
                else
                begin
                    word_next  = word_reg + 7'd1;
                    state_next = S_ST_HI_RD;
                end
            end
            S_STAT:
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    emit_item.kind   = KIND_STATUS;
                    emit_item.status = status_reg;
                    if (eof_reg)
                        rxcnt_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rxcnt_reg     <= '0;
            pfn_reg       <= FN_IDLE;
            pstart_reg    <= 6'd0;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            slave_reg     <= SLAVE_RST;
            wbase_reg     <= WBASE_RST;
            rbase_reg     <= RBASE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rxcnt_reg     <= rxcnt_next;
            pfn_reg       <= pfn_next;
            pstart_reg    <= pstart_next;
            eof_reg       <= eof_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLAVE: slave_reg <= cfg_data[7:0];
                    CFG_WBASE: wbase_reg <= cfg_data;
                    CFG_RBASE: rbase_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        word_reg     <= word_next;
        ptr_reg      <= ptr_next;
        len_reg      <= len_next;
        bytes_reg    <= bytes_next;
        byte_reg     <= byte_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        wr_reg       <= wr_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
    end

    // Holding store
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        if (st_re)
            st_rdata_reg <= store_mem[st_raddr];
    end

    // Receive buffer
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rxcnt_reg[RX_AW-1:0]] <= in_data.rx_byte;
        if (rx_re)
            rx_rdata_reg <= rx_mem[rx_raddr];
    end

endmodule
